### hdl/k_way_heap_merge_unit_assert.svh
// Assertion macros used by the heap engine module.
`ifndef K_WAY_HEAP_MERGE_UNIT_ASSERT_SVH
`define K_WAY_HEAP_MERGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KWM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");
`define KWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define KWM_ASSERT_ALWAYS(lbl, cond)
`define KWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/kwm_pkg.sv
// Types, constants and the ordering function of the heap merge unit.
package kwm_pkg;

  localparam int KeyW = 32;
  localparam int RunW = 4;
  localparam int CntCfgW = 5;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_MERGING,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_NEXT,
    ST_BUILD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_ROOT_RD,
    ST_ROOT_EMIT,
    ST_DONE_EMIT
  } state_t;

  // Bit 32 of the key marks an exhausted run, which sorts after any key.
  typedef struct packed {
    logic [KeyW:0]   key;
    logic [RunW-1:0] run;
    logic [KeyW-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   is_next;
    entry_t ent;
  } cmd_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] payload;
    logic [RunW-1:0] run;
    logic            done;
  } res_t;

  typedef struct packed {
    logic cfg_ok;
  } status_t;

  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.key != b.key) r = (a.key < b.key);
    else r = (a.run < b.run);
    return r;
  endfunction

endpackage

### hdl/kwm_front.sv
// Input front: decodes items and queues them for the heap engine.
module kwm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [71:0]   s_axis_tdata,  // run_index, record_key, record_payload, zero fill
  input  logic [1:0]    s_axis_tuser,  // action, run_exhausted
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output kwm_pkg::cmd_t cmd
);

  kwm_pkg::cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  kwm_pkg::cmd_t dec;
  logic push;
  logic pop;

  always_comb begin
    dec.is_next     = s_axis_tuser[0];
    dec.ent.run     = s_axis_tdata[3:0];
    if (s_axis_tuser[1]) begin
      dec.ent.key     = {1'b1, 32'd0};
      dec.ent.payload = '0;
    end else begin
      dec.ent.key     = {1'b0, s_axis_tdata[35:4]};
      dec.ent.payload = s_axis_tdata[67:36];
    end
  end

  assign s_axis_tready = (fill != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign cmd_valid = (fill != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

### hdl/kwm_heap.sv
// Heap engine: loads run heads, builds the heap and sifts the root down.
`include "k_way_heap_merge_unit_assert.svh"
module kwm_heap #(
  parameter int MAX_RUNS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  kwm_pkg::cmd_t                     cmd,
  input  logic [$clog2(MAX_RUNS+1)-1:0]     n_eff,
  output logic                              res_valid,
  input  logic                              res_ready,
  output kwm_pkg::res_t                     res,
  output kwm_pkg::status_t                  status
);

  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int LW = AW + 2;

  kwm_pkg::entry_t mem [MAX_RUNS];
  kwm_pkg::entry_t rdata_a, rdata_b;

  kwm_pkg::state_t state, state_next;
  kwm_pkg::phase_t phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] bi, bi_next;
  logic [AW-1:0] si, si_next;
  logic          building, building_next;
  logic [kwm_pkg::RunW-1:0] last_run, last_run_next;
  kwm_pkg::entry_t cur, cur_next;

  logic          we;
  logic [AW-1:0] waddr;
  kwm_pkg::entry_t wdata;
  logic          re_a, re_b;
  logic [AW-1:0] raddr_a, raddr_b;

  logic [LW-1:0] l_ext, r_ext, n_ext;
  logic          l_in, r_in;
  logic          take_l, take_r;
  kwm_pkg::entry_t best;
  logic [CW-1:0] slot;

  assign n_ext = LW'(n_eff);
  assign l_ext = {1'b0, si, 1'b1};
  assign r_ext = l_ext + LW'(1);
  assign l_in = (l_ext < n_ext);
  assign r_in = (r_ext < n_ext);

  always_comb begin
    take_l = kwm_pkg::entry_before(rdata_a, cur);
    best = take_l ? rdata_a : cur;
    take_r = r_in && kwm_pkg::entry_before(rdata_b, best);
    if (take_r) best = rdata_b;
  end

  always_comb begin
    if (phase == kwm_pkg::PH_DONE || count >= n_eff) slot = n_eff - CW'(1);
    else slot = count;
    if (phase == kwm_pkg::PH_DONE) slot = '0;
  end

  // Next state and datapath registers.
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    count_next    = count;
    bi_next       = bi;
    si_next       = si;
    building_next = building;
    last_run_next = last_run;
    cur_next      = cur;
    unique case (state)
      kwm_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (phase == kwm_pkg::PH_DONE && cmd.is_next) begin
            state_next = kwm_pkg::ST_DONE_EMIT;
          end else if (phase != kwm_pkg::PH_MERGING && !cmd.is_next) begin
            phase_next = kwm_pkg::PH_LOADING;
            count_next = slot + CW'(1);
            if (slot + CW'(1) == n_eff) begin
              phase_next    = kwm_pkg::PH_MERGING;
              building_next = 1'b1;
              bi_next       = n_eff >> 1;
              state_next    = kwm_pkg::ST_BUILD_NEXT;
            end
          end else if (phase == kwm_pkg::PH_MERGING && cmd.is_next) begin
            cur_next         = cmd.ent;
            cur_next.run     = last_run;
            si_next          = '0;
            building_next    = 1'b0;
            state_next       = kwm_pkg::ST_SIFT_RD;
          end
        end
      end
      kwm_pkg::ST_BUILD_NEXT: begin
        if (bi == '0) begin
          state_next = kwm_pkg::ST_ROOT_RD;
        end else begin
          bi_next    = bi - CW'(1);
          state_next = kwm_pkg::ST_BUILD_LD;
        end
      end
      kwm_pkg::ST_BUILD_LD: begin
        cur_next   = rdata_a;
        si_next    = bi[AW-1:0];
        state_next = kwm_pkg::ST_SIFT_RD;
      end
      kwm_pkg::ST_SIFT_RD: begin
        if (!l_in) state_next = building ? kwm_pkg::ST_BUILD_NEXT : kwm_pkg::ST_ROOT_RD;
        else state_next = kwm_pkg::ST_SIFT_CMP;
      end
      kwm_pkg::ST_SIFT_CMP: begin
        if (!take_l && !take_r) begin
          state_next = building ? kwm_pkg::ST_BUILD_NEXT : kwm_pkg::ST_ROOT_RD;
        end else begin
          si_next    = take_r ? r_ext[AW-1:0] : l_ext[AW-1:0];
          state_next = kwm_pkg::ST_SIFT_RD;
        end
      end
      kwm_pkg::ST_ROOT_RD: state_next = kwm_pkg::ST_ROOT_EMIT;
      kwm_pkg::ST_ROOT_EMIT: begin
        if (res_ready) begin
          last_run_next = rdata_a.run;
          if (rdata_a.key[kwm_pkg::KeyW]) phase_next = kwm_pkg::PH_DONE;
          state_next = kwm_pkg::ST_IDLE;
        end
      end
      kwm_pkg::ST_DONE_EMIT: begin
        if (res_ready) state_next = kwm_pkg::ST_IDLE;
      end
      default: state_next = kwm_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    cmd_ready = 1'b0;
    res_valid = 1'b0;
    we        = 1'b0;
    waddr     = si;
    wdata     = cur;
    re_a      = 1'b0;
    re_b      = 1'b0;
    raddr_a   = l_ext[AW-1:0];
    raddr_b   = r_ext[AW-1:0];
    unique case (state)
      kwm_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        waddr = slot[AW-1:0];
        wdata = cmd.ent;
        we = cmd_valid && !cmd.is_next && phase != kwm_pkg::PH_MERGING;
      end
      kwm_pkg::ST_BUILD_NEXT: begin
        re_a    = (bi != '0);
        raddr_a = AW'(bi - CW'(1));
      end
      kwm_pkg::ST_SIFT_RD: begin
        we   = !l_in;
        re_a = l_in;
        re_b = l_in;
      end
      kwm_pkg::ST_SIFT_CMP: begin
        we    = 1'b1;
        wdata = (take_l || take_r) ? best : cur;
      end
      kwm_pkg::ST_ROOT_RD: begin
        re_a    = 1'b1;
        raddr_a = '0;
      end
      kwm_pkg::ST_ROOT_EMIT: res_valid = 1'b1;
      kwm_pkg::ST_DONE_EMIT: res_valid = 1'b1;
      default: cmd_ready = 1'b0;
    endcase
  end

  always_comb begin
    res.done    = (state == kwm_pkg::ST_DONE_EMIT) || rdata_a.key[kwm_pkg::KeyW];
    res.key     = res.done ? '0 : rdata_a.key[kwm_pkg::KeyW-1:0];
    res.payload = res.done ? '0 : rdata_a.payload;
    res.run     = res.done ? '0 : rdata_a.run;
  end

  assign status.cfg_ok = (state == kwm_pkg::ST_IDLE) &&
                         ((phase == kwm_pkg::PH_DONE) ||
                          (phase == kwm_pkg::PH_LOADING && count == '0));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re_a) rdata_a <= mem[raddr_a];
    if (re_b) rdata_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    si       <= si_next;
    bi       <= bi_next;
    last_run <= last_run_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kwm_pkg::ST_IDLE;
      phase    <= kwm_pkg::PH_LOADING;
      count    <= '0;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      count    <= count_next;
      building <= building_next;
    end
  end

  `KWM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  `KWM_ASSERT_ALWAYS(a_count_bound, phase != kwm_pkg::PH_LOADING || count <= n_eff)
  `KWM_ASSERT_ALWAYS(a_sift_bound, state != kwm_pkg::ST_SIFT_RD || LW'(si) < n_ext)

endmodule

### hdl/k_way_heap_merge_unit.sv
// Top level of the k-way heap merge unit: config register, front, engine, output register.
// A load item that does not complete the set passes through the front queue and is then
// written into the heap; the last load builds the heap by sifting down each internal node,
// then emits the minimum.
// A next item replaces the root and is sifted down the heap over the two-read-port heap
// memory, then the new minimum is emitted.
// Synchronous reset clears the queue, phase, load count and sets run_count to 16;
// heap contents are not cleared.
module k_way_heap_merge_unit #(
  parameter int MAX_RUNS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // run_index, record_key, record_payload, zero fill
  input  logic [1:0]  s_axis_tuser,  // action, run_exhausted
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // out_key, out_payload, out_run, zero fill
  output logic [0:0]  m_axis_tuser,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int CW = $clog2(MAX_RUNS + 1);

  logic [kwm_pkg::CntCfgW-1:0] run_count;
  logic [CW-1:0] n_eff;
  logic cmd_valid, cmd_ready;
  kwm_pkg::cmd_t cmd;
  logic res_valid, res_ready;
  kwm_pkg::res_t res;
  kwm_pkg::status_t status;
  kwm_pkg::res_t out_res;

  always_comb begin
    if (run_count == '0) n_eff = CW'(1);
    else if (int'(run_count) > MAX_RUNS) n_eff = CW'(MAX_RUNS);
    else n_eff = CW'(run_count);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) run_count <= 5'd16;
    else if (cfg_valid && status.cfg_ok) run_count <= cfg_data;
  end

  kwm_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  kwm_heap #(.MAX_RUNS(MAX_RUNS)) u_heap (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .n_eff(n_eff),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .status(status)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (res_valid && res_ready) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {4'd0, out_res.run, out_res.payload, out_res.key};
  assign m_axis_tuser = out_res.done;

endmodule

### tb/sv/k_way_heap_merge_unit_tb.sv
// Self-checking testbench for the k-way heap merge unit: directed cases, then random runs merged and compared.
`timescale 1ns / 1ps

class merge_scoreboard;
  logic [32:0] hkey[16];
  logic [3:0]  hrun[16];
  logic [31:0] hpay[16];
  int unsigned loaded;
  kwm_pkg::phase_t phase;
  int unsigned runs_cfg;
  logic [31:0] exp_key[$];
  logic [31:0] exp_pay[$];
  logic [3:0]  exp_run[$];
  logic        exp_done[$];
  int errors;

  function new();
    loaded = 0;
    phase = kwm_pkg::PH_LOADING;
    runs_cfg = 16;
    errors = 0;
  endfunction

  function int unsigned active_runs();
    int unsigned n;
    n = runs_cfg;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function bit slot_first(int a, int b);
    bit r;
    if (hkey[a] != hkey[b]) r = hkey[a] < hkey[b];
    else r = hrun[a] < hrun[b];
    return r;
  endfunction

  function void sift(int i, int n);
    int l, m;
    logic [32:0] k;
    logic [3:0] r;
    logic [31:0] p;
    while (i < n) begin
      l = 2 * i + 1;
      m = i;
      if (l >= n) break;
      if (slot_first(l, m)) m = l;
      if (l + 1 < n && slot_first(l + 1, m)) m = l + 1;
      if (m == i) break;
      k = hkey[i]; r = hrun[i]; p = hpay[i];
      hkey[i] = hkey[m]; hrun[i] = hrun[m]; hpay[i] = hpay[m];
      hkey[m] = k; hrun[m] = r; hpay[m] = p;
      i = m;
    end
  endfunction

  function void push_result(logic [31:0] k, logic [31:0] p, logic [3:0] r, logic d);
    exp_key.push_back(k); exp_pay.push_back(p); exp_run.push_back(r);
    exp_done.push_back(d);
  endfunction

  function void emit_min();
    if (hkey[0][32]) begin
      phase = kwm_pkg::PH_DONE;
      push_result('0, '0, '0, 1'b1);
    end else begin
      push_result(hkey[0][31:0], hpay[0], hrun[0], 1'b0);
    end
  endfunction

  function void note_config(logic [4:0] v);
    if (phase == kwm_pkg::PH_MERGING) return;
    if (phase == kwm_pkg::PH_LOADING && loaded != 0) return;
    runs_cfg = v;
  endfunction

  function void note_input(bit is_next, logic [3:0] ridx, logic [31:0] k,
                           logic [31:0] p, bit gone);
    int unsigned n, slot;
    logic [32:0] k33;
    n = active_runs();
    k33 = gone ? {1'b1, 32'd0} : {1'b0, k};
    if (phase == kwm_pkg::PH_DONE) begin
      if (is_next) begin
        push_result('0, '0, '0, 1'b1);
        return;
      end
      phase = kwm_pkg::PH_LOADING;
      loaded = 0;
    end
    if (phase == kwm_pkg::PH_LOADING) begin
      if (is_next) return;
      slot = (loaded >= n) ? n - 1 : loaded;
      hkey[slot] = k33; hrun[slot] = ridx; hpay[slot] = gone ? '0 : p;
      loaded = slot + 1;
      if (loaded < n) return;
      for (int i = n / 2 - 1; i >= 0; i--) sift(i, n);
      phase = kwm_pkg::PH_MERGING;
      emit_min();
      return;
    end
    if (!is_next) return;
    hkey[0] = k33;
    hpay[0] = gone ? '0 : p;
    sift(0, n);
    emit_min();
  endfunction

  function void check_result(logic [31:0] k, logic [31:0] p, logic [3:0] r, logic d);
    logic [31:0] ek, ep;
    logic [3:0] er;
    logic ed;
    if (exp_key.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result key=%h run=%0d done=%b", k, r, d);
      return;
    end
    ek = exp_key.pop_front(); ep = exp_pay.pop_front();
    er = exp_run.pop_front(); ed = exp_done.pop_front();
    if (k !== ek || p !== ep || r !== er || d !== ed) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp key=%h pay=%h run=%0d done=%b got key=%h pay=%h run=%0d done=%b",
                 ek, ep, er, ed, k, p, r, d);
    end
  endfunction

  function int pending();
    return exp_key.size();
  endfunction
endclass

module k_way_heap_merge_unit_tb;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  merge_scoreboard merge_sb;
  int accepted_items;
  int unsigned run_pos[16];
  int unsigned run_len[16];
  logic [31:0] run_last[16];
  logic [3:0] last_run;

  k_way_heap_merge_unit u_top (.*);

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random stalls, each result checked at acceptance.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk iff m_axis_tvalid);
      merge_sb.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[67:64],
                            m_axis_tuser[0]);
    end
  end

  // The valid stays high between items sent without a gap; drain() drops it.
  task automatic send_item(bit is_next, logic [3:0] ridx, logic [31:0] k, logic [31:0] p,
                           bit gone, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, p, k, ridx};
    s_axis_tuser <= {gone, is_next};
    @(posedge clk iff s_axis_tready);
    merge_sb.note_input(is_next, ridx, k, p, gone);
    accepted_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (merge_sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_run_count(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    merge_sb.note_config(v);
    cfg_valid <= 1'b0;
  endtask

  // One full merge of n ascending runs with random content and key spread.
  task automatic merge_runs(int unsigned n, int unsigned max_len, int unsigned step);
    logic [31:0] k;
    bool_loop: for (int r = 0; r < n; r++) begin
      run_len[r] = $urandom_range(0, max_len);
      run_pos[r] = 0;
      run_last[r] = $urandom_range(0, step);
      send_item(0, r[3:0], run_last[r], $urandom, run_len[r] == 0);
    end
    while (1) begin
      drain();
      if (merge_sb.phase == kwm_pkg::PH_DONE) break;
      last_run = m_axis_tdata[67:64];
      run_pos[last_run]++;
      if (run_pos[last_run] >= run_len[last_run]) begin
        send_item(1, $urandom, $urandom, $urandom, 1);
      end else begin
        k = run_last[last_run] + $urandom_range(0, step);
        if (k < run_last[last_run]) k = 32'hFFFFFFFF;
        run_last[last_run] = k;
        send_item(1, $urandom, k, $urandom, 0);
      end
    end
  endtask

  initial begin
    int unsigned n;
    merge_sb = new();
    accepted_items = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two runs, extreme keys and payloads, ties, stray items.
    write_run_count(5'd2);
    send_item(1, 4'd0, 32'd5, 32'd5, 0);                 // next while loading: ignored
    send_item(0, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_item(0, 4'd3, 32'hFFFFFFFF, 32'h0, 0);          // tie: lower run wins
    drain();
    send_item(0, 4'd1, 32'd0, 32'd1, 0);                 // load while merging: ignored
    send_item(1, 4'd0, 32'hFFFFFFFF, 32'hA5A5A5A5, 0);
    drain();
    write_run_count(5'd9);                               // ignored while merging
    send_item(1, 4'd0, 32'd0, 32'd0, 1);
    send_item(1, 4'd0, 32'd0, 32'd0, 1);
    send_item(1, 4'd0, 32'd0, 32'd0, 1);                 // done repeated
    drain();
    write_run_count(5'd0);                               // clamps to one run
    send_item(0, 4'd7, 32'd0, 32'd0, 1);                 // exhausted at once
    drain();
    write_run_count(5'd31);                              // clamps to sixteen
    for (int r = 0; r < 16; r++) send_item(0, 4'd5, $urandom, $urandom, r[0], 1);
    drain();
    for (int r = 0; r < 16; r++) send_item(1, 4'd0, 32'd0, 32'd0, 1);
    drain();

    // Random merges over several run counts; the drain between items is the
    // required pause until all expected results have come.
    while (accepted_items < 420) begin
      n = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 16);
      write_run_count(n[4:0]);
      merge_runs(n, $urandom_range(0, 4), ($urandom_range(0, 1) != 0) ? 3 : 32'h3FFFFFFF);
      if ($urandom_range(0, 4) == 0) send_item(1, $urandom, $urandom, $urandom, $urandom);
      drain();
    end
    drain();

    if (merge_sb.errors == 0 && merge_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### k_way_heap_merge_unit.f
+incdir+hdl
hdl/kwm_pkg.sv
hdl/kwm_front.sv
hdl/kwm_heap.sv
hdl/k_way_heap_merge_unit.sv
tb/sv/k_way_heap_merge_unit_tb.sv
